// ----- src/rlab_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RGB lookup table / alpha blend block.
// No dependencies; imported by every module of the block.

package rlab_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CHAN_MAX = 8'd255;
  localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

  // x / 255 == (x * 0x8081) >> 23 for every 16-bit x
  localparam logic [15:0] DIV255_MUL = 16'h8081;
  localparam int DIV255_SHIFT = 23;

  typedef enum logic {
    ACTION_PIXEL = 1'b0,
    ACTION_LOAD  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CHAN_RED   = 2'd0,
    CHAN_GREEN = 2'd1,
    CHAN_BLUE  = 2'd2
  } chan_t;

  // one pixel beat after the table read, queued between front and back
  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
    logic [7:0]  red_lut;
    logic [7:0]  green_lut;
    logic [7:0]  blue_lut;
  } rlab_entry_t;

endpackage

// ----- src/rlab_fifo.sv -----
`timescale 1ns / 1ps
// Short queue between the table front end and the blend back end.
// Depends on rlab_pkg for the entry type.

module rlab_fifo #(
  parameter int Depth = rlab_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  rlab_pkg::rlab_entry_t       push_data,
  input  logic                        pop,
  output logic                        not_empty,
  output rlab_pkg::rlab_entry_t       head,
  output logic [$clog2(Depth+1)-1:0]  count
);
  import rlab_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  rlab_entry_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CountW'(1);
        2'b01:   count <= count - CountW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CountW'(Depth)) || pop)
    else $error("rlab_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("rlab_fifo: pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CountW'(1)))
    else $error("rlab_fifo: count did not follow push");
`endif

endmodule

// ----- src/rlab_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts beats, writes table loads, reads the three tables for pixels
// and pushes the looked-up pixel into the queue. Depends on rlab_pkg.

module rlab_front #(
  parameter int Depth = rlab_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [31:0]                 pixel_in,
  input  logic                        last_pixel,
  input  logic [1:0]                  table_channel,
  input  logic [7:0]                  table_index,
  input  logic [7:0]                  table_value,
  input  logic [$clog2(Depth+1)-1:0]  fifo_count,
  output logic                        push,
  output rlab_pkg::rlab_entry_t       push_data
);
  import rlab_pkg::*;

  localparam int SumW = $clog2(Depth + 1) + 1;

  logic [7:0] red_mem   [256];
  logic [7:0] green_mem [256];
  logic [7:0] blue_mem  [256];

  logic        accept;
  logic        rd_en;
  logic        wr_red;
  logic        wr_green;
  logic        wr_blue;
  logic [SumW-1:0] level;

  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic        s1_last;
  logic [7:0]  red_rd;
  logic [7:0]  green_rd;
  logic [7:0]  blue_rd;

  // reserve a queue slot for the beat in the read stage
  assign level    = SumW'(fifo_count) + SumW'(s1_valid);
  assign in_stall = (level >= SumW'(Depth));
  assign accept   = in_valid && !in_stall;
  assign rd_en    = accept && (action_t'(action) == ACTION_PIXEL);

  always_comb begin
    wr_red   = 1'b0;
    wr_green = 1'b0;
    wr_blue  = 1'b0;
    if (accept && (action_t'(action) == ACTION_LOAD)) begin
      unique case (table_channel)
        CHAN_RED:   wr_red   = 1'b1;
        CHAN_GREEN: wr_green = 1'b1;
        CHAN_BLUE:  wr_blue  = 1'b1;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_red) begin
      red_mem[table_index] <= table_value;
    end
    if (rd_en) begin
      red_rd <= red_mem[pixel_in[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_green) begin
      green_mem[table_index] <= table_value;
    end
    if (rd_en) begin
      green_rd <= green_mem[pixel_in[15:8]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_blue) begin
      blue_mem[table_index] <= table_value;
    end
    if (rd_en) begin
      blue_rd <= blue_mem[pixel_in[23:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pixel <= pixel_in;
      s1_last  <= last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en;
    end
  end

  assign push                = s1_valid;
  assign push_data.pixel     = s1_pixel;
  assign push_data.last      = s1_last;
  assign push_data.red_lut   = red_rd;
  assign push_data.green_lut = green_rd;
  assign push_data.blue_lut  = blue_rd;

`ifndef SYNTHESIS
  a_load_no_push: assert property (@(posedge clk) disable iff (rst)
    (accept && (action_t'(action) == ACTION_LOAD)) |=> !push)
    else $error("rlab_front: load beat produced a pixel");

  a_pixel_push: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> push)
    else $error("rlab_front: pixel beat lost after table read");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= SumW'(Depth))
    else $error("rlab_front: queue reservation exceeded");
`endif

endmodule

// ----- src/rlab_back.sv -----
`timescale 1ns / 1ps
// Back end: pops looked-up pixels, blends with the input by alpha and drives the
// output register. Holds the alpha_blend register. Depends on rlab_pkg.

module rlab_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   fifo_not_empty,
  input  rlab_pkg::rlab_entry_t  fifo_head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            pixel_out,
  output logic                   frame_end
);
  import rlab_pkg::*;

  logic        alpha_blend;
  logic        advance;

  logic        b1_valid;
  logic [31:0] b1_pixel;
  logic        b1_last;
  logic [7:0]  b1_lut   [3];
  logic [15:0] b1_sum   [3];

  logic [7:0]  chan_res [3];

  function automatic logic [15:0] blend_sum(input logic [7:0] px, input logic [7:0] lut,
                                            input logic [7:0] a);
    logic [15:0] inv_term;
    logic [15:0] lut_term;
    inv_term = {8'd0, CHAN_MAX - a} * {8'd0, px};
    lut_term = {8'd0, a} * {8'd0, lut};
    return inv_term + lut_term;
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [31:0] prod;
    prod = {16'd0, s} * {16'd0, DIV255_MUL};
    return prod[DIV255_SHIFT +: 8];
  endfunction

  assign advance = !out_valid || !out_stall;
  assign pop     = fifo_not_empty && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_blend <= 1'b0;
    end else if (cfg_wr_en) begin
      alpha_blend <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_pixel  <= fifo_head.pixel;
      b1_last   <= fifo_head.last;
      b1_lut[0] <= fifo_head.red_lut;
      b1_lut[1] <= fifo_head.green_lut;
      b1_lut[2] <= fifo_head.blue_lut;
      b1_sum[0] <= blend_sum(fifo_head.pixel[7:0], fifo_head.red_lut,
                             fifo_head.pixel[31:24]);
      b1_sum[1] <= blend_sum(fifo_head.pixel[15:8], fifo_head.green_lut,
                             fifo_head.pixel[31:24]);
      b1_sum[2] <= blend_sum(fifo_head.pixel[23:16], fifo_head.blue_lut,
                             fifo_head.pixel[31:24]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan_res[i] = alpha_blend ? div255(b1_sum[i]) : b1_lut[i];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b1_valid) begin
      pixel_out <= (b1_pixel & ALPHA_MASK) | {8'd0, chan_res[2], chan_res[1], chan_res[0]};
      frame_end <= b1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b1_valid  <= pop;
      out_valid <= b1_valid;
    end
  end

`ifndef SYNTHESIS
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("rlab_back: popped while output blocked");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (b1_valid && advance) |=> out_valid)
    else $error("rlab_back: blend stage result dropped");

  a_alpha_copy: assert property (@(posedge clk) disable iff (rst)
    (b1_valid && advance) |=> (pixel_out[31:24] == $past(b1_pixel[31:24])))
    else $error("rlab_back: alpha byte not copied");
`endif

endmodule

// ----- src/rgb_lut_alpha_blend.sv -----
`timescale 1ns / 1ps
// Top level of the per-channel RGB lookup table with optional alpha blend.
// Depends on rlab_pkg, rlab_front, rlab_fifo and rlab_back.

// Every beat is either a table load (writes one byte of the red, green or blue
// table, or none if table_channel is 3, and gives no result) or a pixel (gives
// exactly one result). One beat is taken per clock while in_stall is low, loads
// and pixels alike. The tables are read at the accepting edge; then come the
// queue, the blend products, and the divide by 255 together with the output
// register. A load is visible to a pixel accepted in the very next cycle.
// With alpha_blend set each color byte becomes ((255 - a) * in + a * table[in])
// divided by 255, truncated; alpha is always copied. The queue holds FifoDepth
// pixels, so a short output stall does not block the input; a longer one fills
// the queue and then stalls every beat, loads included. Write alpha_blend only
// while no pixel is in flight.

module rgb_lut_alpha_blend #(
  parameter int FifoDepth = rlab_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] pixel_in,
  input  logic        last_pixel,
  input  logic [1:0]  table_channel,
  input  logic [7:0]  table_index,
  input  logic [7:0]  table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_out,
  output logic        frame_end
);
  import rlab_pkg::*;

  logic                             push;
  rlab_entry_t                      push_data;
  logic                             pop;
  logic                             fifo_not_empty;
  rlab_entry_t                      fifo_head;
  logic [$clog2(FifoDepth+1)-1:0]   fifo_count;

  rlab_front #(
    .Depth(FifoDepth)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .pixel_in      (pixel_in),
    .last_pixel    (last_pixel),
    .table_channel (table_channel),
    .table_index   (table_index),
    .table_value   (table_value),
    .fifo_count    (fifo_count),
    .push          (push),
    .push_data     (push_data)
  );

  rlab_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (fifo_not_empty),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  rlab_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fifo_not_empty (fifo_not_empty),
    .fifo_head      (fifo_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_out      (pixel_out),
    .frame_end      (frame_end)
  );

endmodule

// ----- test/rgb_lut_alpha_blend_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgb_lut_alpha_blend: table loads, pixel lookups and
// alpha blending, with random idling on both sides. Depends on rlab_pkg and the RTL.

module rgb_lut_alpha_blend_tb;
  import rlab_pkg::*;

  localparam logic [1:0] CHAN_NONE = 2'd3;

  class lut_scoreboard;
    bit         blend_on;
    bit [7:0]   lut [3][256];
    bit [31:0]  exp_pixel_q [$];
    bit         exp_end_q [$];
    int         errors;

    function bit [7:0] mix(bit [7:0] x, bit [7:0] mapped, bit [7:0] a);
      int unsigned sum;
      if (!blend_on) return mapped;
      sum = (int'(CHAN_MAX) - int'(a)) * int'(x) + int'(a) * int'(mapped);
      return 8'(sum / int'(CHAN_MAX));
    endfunction

    function void note_beat(logic act, logic [31:0] pix, logic lst, logic [1:0] ch,
                            logic [7:0] idx, logic [7:0] val);
      bit [31:0] word;
      if (act == ACTION_LOAD) begin
        if (ch == CHAN_RED || ch == CHAN_GREEN || ch == CHAN_BLUE) lut[ch][idx] = val;
        return;
      end
      word[7:0]   = mix(pix[7:0],   lut[CHAN_RED][pix[7:0]],     pix[31:24]);
      word[15:8]  = mix(pix[15:8],  lut[CHAN_GREEN][pix[15:8]],  pix[31:24]);
      word[23:16] = mix(pix[23:16], lut[CHAN_BLUE][pix[23:16]],  pix[31:24]);
      word[31:24] = pix[31:24];
      exp_pixel_q.push_back(word);
      exp_end_q.push_back(lst);
    endfunction

    function void check_result(logic [31:0] pix, logic fe);
      bit [31:0] want_pix;
      bit        want_end;
      if (exp_pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: pixel_out=%h frame_end=%b", pix, fe);
        return;
      end
      want_pix = exp_pixel_q.pop_front();
      want_end = exp_end_q.pop_front();
      if (pix !== want_pix || fe !== want_end) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: pixel_out exp %h got %h, frame_end exp %b got %b",
                   want_pix, pix, want_end, fe);
      end
    endfunction

    function int pending();
      return exp_pixel_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [31:0] pixel_in;
  logic        last_pixel;
  logic [1:0]  table_channel;
  logic [7:0]  table_index;
  logic [7:0]  table_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] pixel_out;
  logic        frame_end;

  lut_scoreboard sb = new;
  bit            written [3][256];
  bit            calm;
  int            hold_len;

  rgb_lut_alpha_blend dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .pixel_in(pixel_in),
    .last_pixel(last_pixel),
    .table_channel(table_channel),
    .table_index(table_index),
    .table_value(table_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_out(pixel_out),
    .frame_end(frame_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) sb.blend_on = cfg_wr_data;
      if (in_valid && !in_stall)
        sb.note_beat(action, pixel_in, last_pixel, table_channel, table_index, table_value);
      if (out_valid && !out_stall) sb.check_result(pixel_out, frame_end);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic act, input logic [31:0] pix, input logic lst,
                           input logic [1:0] ch, input logic [7:0] idx,
                           input logic [7:0] val);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    pixel_in      <= pix;
    last_pixel    <= lst;
    table_channel <= ch;
    table_index   <= idx;
    table_value   <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_entry(input logic [1:0] ch, input logic [7:0] idx, input logic [7:0] val);
    if (ch != CHAN_NONE) written[ch][idx] = 1'b1;
    send_beat(ACTION_LOAD, $urandom, 1'($urandom), ch, idx, val);
  endtask

  task automatic send_pixel(input logic [31:0] pix, input logic lst);
    send_beat(ACTION_PIXEL, pix, lst, 2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a random index whose entry has been loaded for this channel
  function automatic logic [7:0] pick_index(input int ch);
    logic [7:0] start;
    logic [7:0] idx;
    start = 8'($urandom);
    for (int k = 0; k < 256; k++) begin
      idx = start + 8'(k);
      if (written[ch][idx]) return idx;
    end
    return 8'd0;
  endfunction

  task automatic random_beat();
    logic [31:0] pix;
    if ($urandom_range(0, 3) == 0) begin
      load_entry(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    end else begin
      pix = {8'($urandom), pick_index(CHAN_BLUE), pick_index(CHAN_GREEN),
             pick_index(CHAN_RED)};
      send_pixel(pix, $urandom_range(0, 15) == 0);
    end
  endtask

  // one edge first so the last accepted beat is already noted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_blend(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic directed_pixels();
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h8080_8080, 1'b0);
    send_pixel(32'h7FFF_8000, 1'b0);
    send_pixel(32'h0100_FF80, 1'b1);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_valid      = 1'b0;
    action        = ACTION_PIXEL;
    pixel_in      = '0;
    last_pixel    = 1'b0;
    table_channel = CHAN_RED;
    table_index   = '0;
    table_value   = '0;
    calm          = 1'b0;
    hold_len      = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_blend(1'b0);
    for (int c = 0; c < 3; c++) begin
      load_entry(2'(c), 8'h00, 8'hFF);
      load_entry(2'(c), 8'hFF, 8'h00);
      load_entry(2'(c), 8'h80, 8'h7F);
    end
    // bad channel must not touch any table
    load_entry(CHAN_NONE, 8'h00, 8'h55);
    directed_pixels();
    drain();
    write_blend(1'b1);
    directed_pixels();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_blend(ph % 2 == 1);
      if (ph == 2) hold_len = 60;
      if (ph == 5) calm = 1'b1;
      repeat (325) random_beat();
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rlab_pkg.sv
src/rlab_fifo.sv
src/rlab_front.sv
src/rlab_back.sv
src/rgb_lut_alpha_blend.sv
test/rgb_lut_alpha_blend_tb.sv
